/* design/banked_cartridge_mapper_with_clock_assert.svh */
// Assertion macros for the verification file of the cartridge mapper.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef BANKED_CARTRIDGE_MAPPER_WITH_CLOCK_ASSERT_SVH
`define BANKED_CARTRIDGE_MAPPER_WITH_CLOCK_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bcm_pkg.sv */
// Shared types, codes and constants for the banked cartridge mapper.
// No dependencies; imported by every module of the block.
package bcm_pkg;

  localparam int ROM_BANK_BITS = 7;
  localparam int RAM_BANK_BITS = 2;

  localparam logic [6:0] ROM_BITS_MASK = 7'((1 << ROM_BANK_BITS) - 1);
  localparam logic [1:0] RAM_BITS_MASK = 2'((1 << RAM_BANK_BITS) - 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_ROM_MASK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_MASK = 1'b1;

  localparam logic [6:0] ROM_MASK_RESET = 7'h7F;
  localparam logic [1:0] RAM_MASK_RESET = 2'h3;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] TGT_ROM  = 2'd0;
  localparam logic [1:0] TGT_RAM  = 2'd1;
  localparam logic [1:0] TGT_DATA = 2'd2;
  localparam logic [1:0] TGT_NONE = 2'd3;

  // Address region codes taken from address bits 15:13.
  localparam logic [2:0] REG_RAM_EN   = 3'b000;
  localparam logic [2:0] REG_ROM_BANK = 3'b001;
  localparam logic [2:0] REG_SELECT   = 3'b010;
  localparam logic [2:0] REG_LATCH    = 3'b011;
  localparam logic [2:0] REG_EXT_RAM  = 3'b101;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;

  localparam logic [2:0] CLK_SEC    = 3'd0;
  localparam logic [2:0] CLK_MIN    = 3'd1;
  localparam logic [2:0] CLK_HOUR   = 3'd2;
  localparam logic [2:0] CLK_DAY_LO = 3'd3;
  localparam logic [2:0] CLK_DAY_HI = 3'd4;

  localparam logic [5:0] SEC_LIMIT  = 6'd60;
  localparam logic [5:0] MIN_LIMIT  = 6'd60;
  localparam logic [4:0] HOUR_LIMIT = 5'd24;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [20:0] mem_address;
    logic        mem_write;
    logic [7:0]  read_data;
  } out_item_t;

  typedef struct packed {
    logic       tick;
    logic       clk_wr;
    logic       latch;
    logic [2:0] sel;
    logic [7:0] data;
  } rtc_cmd_t;

endpackage

/* design/bcm_rtc.sv */
// Real-time clock counters, their register writes and the latched copy.
// Depends on bcm_pkg for the command struct and clock register codes.
module bcm_rtc (
  input  logic             clk,
  input  logic             rst_n,
  input  bcm_pkg::rtc_cmd_t cmd,
  output logic [39:0]      latched_clock
);
  import bcm_pkg::*;

  logic [5:0]  sec_r, sec_nxt, min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [8:0]  day_r, day_nxt;
  logic        halt_r, halt_nxt, carry_r, carry_nxt;
  logic [39:0] latch_r, latch_nxt;
  logic [5:0]  sec_inc, min_inc;
  logic [4:0]  hour_inc;
  logic [8:0]  day_inc;

  assign sec_inc  = sec_r + 6'd1;
  assign min_inc  = min_r + 6'd1;
  assign hour_inc = hour_r + 5'd1;
  assign day_inc  = day_r + 9'd1;

  always_comb begin
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    day_nxt   = day_r;
    halt_nxt  = halt_r;
    carry_nxt = carry_r;
    latch_nxt = latch_r;
    if (cmd.tick && !halt_r) begin
      sec_nxt = sec_inc;
      if (sec_inc == SEC_LIMIT) begin
        sec_nxt = 6'd0;
        min_nxt = min_inc;
        if (min_inc == MIN_LIMIT) begin
          min_nxt  = 6'd0;
          hour_nxt = hour_inc;
          if (hour_inc == HOUR_LIMIT) begin
            hour_nxt = 5'd0;
            day_nxt  = day_inc;
            if (day_inc == 9'd0) begin
              carry_nxt = 1'b1;
            end
          end
        end
      end
    end else if (cmd.clk_wr) begin
      case (cmd.sel)
        CLK_SEC:    sec_nxt  = cmd.data[5:0];
        CLK_MIN:    min_nxt  = cmd.data[5:0];
        CLK_HOUR:   hour_nxt = cmd.data[4:0];
        CLK_DAY_LO: day_nxt  = {day_r[8], cmd.data};
        default: begin
          day_nxt   = {cmd.data[0], day_r[7:0]};
          halt_nxt  = cmd.data[6];
          carry_nxt = cmd.data[7];
        end
      endcase
    end
    if (cmd.latch) begin
      latch_nxt = {carry_r, halt_r, 5'd0, day_r[8], day_r[7:0],
                   3'd0, hour_r, 2'd0, min_r, 2'd0, sec_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r   <= 6'd0;
      min_r   <= 6'd0;
      hour_r  <= 5'd0;
      day_r   <= 9'd0;
      halt_r  <= 1'b0;
      carry_r <= 1'b0;
      latch_r <= 40'd0;
    end else begin
      sec_r   <= sec_nxt;
      min_r   <= min_nxt;
      hour_r  <= hour_nxt;
      day_r   <= day_nxt;
      halt_r  <= halt_nxt;
      carry_r <= carry_nxt;
      latch_r <= latch_nxt;
    end
  end

  assign latched_clock = latch_r;

endmodule

/* design/bcm_map.sv */
// Mapper registers, configuration masks and the address decode of one item.
// Depends on bcm_pkg; drives the clock commands consumed by bcm_rtc.
module bcm_map (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fire,
  input  bcm_pkg::in_item_t               item,
  input  logic                            cfg_wr_en,
  input  logic [bcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcm_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  input  logic [39:0]                     latched_clock,
  output bcm_pkg::out_item_t              result,
  output bcm_pkg::rtc_cmd_t               rtc_cmd
);
  import bcm_pkg::*;

  logic       ram_en_r, ram_en_nxt;
  logic [6:0] bank_num_r, bank_num_nxt;
  logic [3:0] sel_r, sel_nxt;
  logic       armed_r, armed_nxt;
  logic [6:0] rom_mask_r, rom_mask_nxt;
  logic [1:0] ram_mask_r, ram_mask_nxt;

  logic [2:0] region;
  logic       sel_ram, sel_clk;
  logic [6:0] rom_eff;
  logic [1:0] ram_eff;
  logic [7:0] clk_byte;

  assign region  = item.address[15:13];
  assign sel_ram = (sel_r[3:2] == 2'b00);
  assign sel_clk = sel_r[3] && (sel_r[2:0] <= CLK_DAY_HI);
  assign rom_eff = bank_num_r & rom_mask_r & ROM_BITS_MASK;
  assign ram_eff = sel_r[1:0] & ram_mask_r & RAM_BITS_MASK;

  always_comb begin
    case (sel_r[2:0])
      CLK_SEC:    clk_byte = latched_clock[7:0];
      CLK_MIN:    clk_byte = latched_clock[15:8];
      CLK_HOUR:   clk_byte = latched_clock[23:16];
      CLK_DAY_LO: clk_byte = latched_clock[31:24];
      default:    clk_byte = latched_clock[39:32];
    endcase
  end

  always_comb begin
    result       = '0;
    result.target = TGT_NONE;
    rtc_cmd      = '0;
    rtc_cmd.sel  = sel_r[2:0];
    rtc_cmd.data = item.write_data;
    ram_en_nxt   = ram_en_r;
    bank_num_nxt = bank_num_r;
    sel_nxt      = sel_r;
    armed_nxt    = armed_r;
    case (item.opcode)
      OP_TICK: rtc_cmd.tick = fire;
      OP_READ: begin
        if (!item.address[15]) begin
          result.target = TGT_ROM;
          result.mem_address = item.address[14] ? {rom_eff, item.address[13:0]}
                                                : {7'd0, item.address[13:0]};
        end else if (region == REG_EXT_RAM) begin
          result.target    = TGT_DATA;
          result.read_data = 8'hFF;
          if (ram_en_r && sel_ram) begin
            result.target      = TGT_RAM;
            result.read_data   = 8'd0;
            result.mem_address = 21'({ram_eff, item.address[12:0]});
          end else if (ram_en_r && sel_clk) begin
            result.read_data = clk_byte;
          end
        end
      end
      OP_WRITE: begin
        case (region)
          REG_RAM_EN: ram_en_nxt = (item.write_data[3:0] == RAM_EN_KEY);
          REG_ROM_BANK: begin
            bank_num_nxt = (item.write_data[6:0] == 7'd0) ? 7'd1 : item.write_data[6:0];
          end
          REG_SELECT: sel_nxt = item.write_data[3:0];
          REG_LATCH: begin
            rtc_cmd.latch = fire && armed_r && (item.write_data == 8'h01);
            armed_nxt     = (item.write_data == 8'h00);
          end
          REG_EXT_RAM: begin
            if (ram_en_r && sel_ram) begin
              result.target      = TGT_RAM;
              result.mem_write   = 1'b1;
              result.mem_address = 21'({ram_eff, item.address[12:0]});
            end else if (ram_en_r && sel_clk) begin
              rtc_cmd.clk_wr = fire;
            end
          end
          default: result.target = TGT_NONE;
        endcase
      end
      default: result.target = TGT_NONE;
    endcase
  end

  always_comb begin
    rom_mask_nxt = rom_mask_r;
    ram_mask_nxt = ram_mask_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ROM_MASK: rom_mask_nxt = cfg_wr_data[6:0];
        CFG_RAM_MASK: ram_mask_nxt = cfg_wr_data[1:0];
        default:      rom_mask_nxt = rom_mask_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_en_r   <= 1'b0;
      bank_num_r <= 7'd1;
      sel_r      <= 4'd0;
      armed_r    <= 1'b0;
      rom_mask_r <= ROM_MASK_RESET;
      ram_mask_r <= RAM_MASK_RESET;
    end else begin
      rom_mask_r <= rom_mask_nxt;
      ram_mask_r <= ram_mask_nxt;
      if (fire) begin
        ram_en_r   <= ram_en_nxt;
        bank_num_r <= bank_num_nxt;
        sel_r      <= sel_nxt;
        armed_r    <= armed_nxt;
      end
    end
  end

endmodule

/* design/banked_cartridge_mapper_with_clock.sv */
// Cartridge mapper with real-time clock: input register, decode, result register.
// An accepted item is held in the input register, decoded, then shown on out_ from the result register.
// Throughput is one item per cycle; only a stalled result register holds input back.
// Reset (sync, active low) clears valid flags and submodule state, not in_r/out_r.
// Depends on bcm_pkg, bcm_map and bcm_rtc.
module banked_cartridge_mapper_with_clock (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  bcm_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output bcm_pkg::out_item_t              out_item,
  input  logic                            cfg_wr_en,
  input  logic [bcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcm_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
  import bcm_pkg::*;

  in_item_t  in_r;
  logic      in_vld_r, in_vld_nxt;
  out_item_t out_r;
  logic      out_vld_r, out_vld_nxt;
  logic      advance, in_acc;
  out_item_t result;
  rtc_cmd_t  rtc_cmd;
  logic [39:0] latched_clock;

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_item;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  bcm_map u_map (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (advance),
    .item          (in_r),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data),
    .latched_clock (latched_clock),
    .result        (result),
    .rtc_cmd       (rtc_cmd)
  );

  bcm_rtc u_rtc (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (rtc_cmd),
    .latched_clock (latched_clock)
  );

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule

/* design/bcm_checker.sv */
// Port-level checks for the cartridge mapper, bound to the top level.
// Depends on bcm_pkg and banked_cartridge_mapper_with_clock_assert.svh.
`include "banked_cartridge_mapper_with_clock_assert.svh"

module bcm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input bcm_pkg::in_item_t               in_item,
  input logic                            out_valid,
  input logic                            out_stall,
  input bcm_pkg::out_item_t              out_item,
  input logic                            cfg_wr_en,
  input logic [bcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [bcm_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
  import bcm_pkg::*;

  `BCM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled item changed")

  `BCM_ASSERT_SAME(a_no_stall_when_empty, !out_valid, !in_stall, "input stalled with empty output")

  `BCM_ASSERT_SAME(a_write_is_ram, out_valid && out_item.mem_write, out_item.target == TGT_RAM, "memory write outside RAM")

  `BCM_ASSERT_SAME(a_data_only_here, out_valid && (out_item.target != TGT_DATA), out_item.read_data == 8'd0, "read data on a non-data item")

  `BCM_ASSERT_SAME(a_addr_only_mem, out_valid && (out_item.target == TGT_DATA || out_item.target == TGT_NONE), out_item.mem_address == 21'd0, "address on a non-memory item")

endmodule

bind banked_cartridge_mapper_with_clock bcm_checker u_bcm_checker (.*);
